@@ design/assert_macros.svh @@
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HLA_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hla_pkg.sv @@
package hla_pkg;

	localparam int CH_W = 8;
	localparam int COLOR_W = 24;
	localparam int DELTA_W = 14;
	localparam int UNIT_W = 17;

	localparam logic [UNIT_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [UNIT_W-1:0] SIXTH_Q16 = 17'd10923;
	localparam logic [UNIT_W-1:0] THIRD_Q16 = 17'd21845;
	localparam logic [UNIT_W-1:0] HALF_Q16 = 17'd32768;
	localparam logic [UNIT_W-1:0] TWO3_Q16 = 17'd43691;
	localparam logic [UNIT_W-1:0] SAT_GRAY = 17'd66;

	// divider: quotient bits, operand width, steps per stage
	localparam int DIV_QW = 17;
	localparam int DIV_DW = 11;
	localparam int DIV_SPS = 2;
	localparam int DIV_STAGES = (DIV_QW + DIV_SPS - 1) / DIV_SPS;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [19:0] v);
		if (v < 20'sd0)
			return '0;
		else if (v > 20'sd65536)
			return ONE_Q16;
		else
			return v[UNIT_W-1:0];
	endfunction

endpackage

@@ design/hla_div.sv @@
module hla_div import hla_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [DIV_DW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_QW-1:0] quo
);

	// restoring division of num * 2^(DIV_QW-1) by den, num <= den
	logic [DIV_DW-1:0] rem_s [DIV_STAGES];
	logic [DIV_DW-1:0] den_s [DIV_STAGES];
	logic [DIV_QW-1:0] quo_s [DIV_STAGES];

	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_st
		logic [DIV_DW-1:0] rem_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_QW-1:0] quo_in;
		logic [DIV_DW-1:0] rem_nx;
		logic [DIV_QW-1:0] quo_nx;

		if (st == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[st-1];
			assign den_in = den_s[st-1];
			assign quo_in = quo_s[st-1];
		end

		always_comb begin
			logic [DIV_DW:0] t;
			rem_nx = rem_in;
			quo_nx = quo_in;
			t = '0;
			for (int k = 0; k < DIV_SPS; k++) begin
				if (st * DIV_SPS + k < DIV_QW) begin
					if (st * DIV_SPS + k == 0)
						t = {1'b0, rem_nx};
					else
						t = {rem_nx, 1'b0};
					if (t >= {1'b0, den_in}) begin
						quo_nx[DIV_QW-1-(st*DIV_SPS+k)] = 1'b1;
						t = t - {1'b0, den_in};
					end
					rem_nx = t[DIV_DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[st] <= rem_nx;
				den_s[st] <= den_in;
				quo_s[st] <= quo_nx;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

@@ design/hsl_lightness_adjust.sv @@
// Channel  Valid      Stall      Payload
// in       in_valid   in_stall   color_in, lightness_delta
// out      out_valid  out_stall  color_out
//
// One request per cycle while the output is not stalled; the pipeline is one input
// stage, the 9-stage bit-pair divider for hue and saturation, and 6 stages of back conversion.
// Reset clears all valid bits; payload registers are not reset.
// A stalled valid output holds the whole pipeline; in_stall follows it the same cycle.
module hsl_lightness_adjust import hla_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [COLOR_W-1:0]        color_in,
	input  logic signed [DELTA_W-1:0] lightness_delta,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COLOR_W-1:0]        color_out
);

	logic adv;

	// stage 1: max, min, divider operands
	logic [CH_W-1:0] r_c, g_c, b_c, mx_c, mn_c, d_c, sden_c;
	logic [8:0] sum_c;
	logic [10:0] sixd_c;
	logic [11:0] num_c;

	logic v_s1;
	logic [8:0] sum_s1;
	logic [CH_W-1:0] d_s1, sden_s1;
	logic [DIV_DW-1:0] num_s1, sixd_s1;
	logic signed [DELTA_W-1:0] delta_s1;

	assign r_c = color_in[7:0];
	assign g_c = color_in[15:8];
	assign b_c = color_in[23:16];

	always_comb begin
		mx_c = r_c;
		mn_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		d_c = mx_c - mn_c;
		sum_c = {1'b0, mx_c} + {1'b0, mn_c};
		sixd_c = 11'({3'b0, d_c} * 11'd6);
		if (sum_c > 9'd255)
			sden_c = 8'(9'd510 - sum_c);
		else
			sden_c = sum_c[7:0];
		priority if (mx_c == r_c)
			num_c = {4'b0, g_c} - {4'b0, b_c} + ((g_c < b_c) ? {1'b0, sixd_c} : 12'd0);
		else if (mx_c == g_c)
			num_c = {4'b0, b_c} - {4'b0, r_c} + {3'b0, d_c, 1'b0};
		else
			num_c = {4'b0, r_c} - {4'b0, g_c} + {2'b0, d_c, 2'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_c;
			d_s1 <= d_c;
			sden_s1 <= sden_c;
			num_s1 <= num_c[DIV_DW-1:0];
			sixd_s1 <= sixd_c;
			delta_s1 <= lightness_delta;
		end
	end

	// lightness with delta, carried beside the dividers
	logic [15:0] y_c;
	logic [UNIT_W-1:0] q255_c, lraw_c, ladj_c;
	logic signed [19:0] dl_c;

	always_comb begin
		y_c = {sum_s1, 7'b0};
		q255_c = ({1'b0, y_c} + {9'b0, y_c[15:8]} + 17'd1) >> 8;
		lraw_c = {1'b0, y_c} + q255_c;
		dl_c = {{(20-DELTA_W){delta_s1[DELTA_W-1]}}, delta_s1};
		ladj_c = clamp_unit($signed({3'b0, lraw_c}) + (dl_c <<< 4));
	end

	logic v_div_s [DIV_STAGES];
	logic [UNIT_W-1:0] l_div_s [DIV_STAGES];
	logic gray_div_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) v_div_s[i] <= 1'b0;
		end else if (adv) begin
			v_div_s[0] <= v_s1;
			for (int i = 1; i < DIV_STAGES; i++) v_div_s[i] <= v_div_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_div_s[0] <= ladj_c;
			gray_div_s[0] <= (d_s1 == '0);
			for (int i = 1; i < DIV_STAGES; i++) begin
				l_div_s[i] <= l_div_s[i-1];
				gray_div_s[i] <= gray_div_s[i-1];
			end
		end
	end

	logic [DIV_QW-1:0] sat_quo, hue_quo;

	hla_div u_sat_div (
		.clk (clk),
		.adv (adv),
		.num ({3'b0, d_s1}),
		.den ({3'b0, sden_s1}),
		.quo (sat_quo)
	);

	hla_div u_hue_div (
		.clk (clk),
		.adv (adv),
		.num (num_s1),
		.den (sixd_s1),
		.quo (hue_quo)
	);

	// stage 11: l*s
	logic [UNIT_W-1:0] sat_c, l_c;
	logic [33:0] ls_prod_c;

	assign l_c = l_div_s[DIV_STAGES-1];
	assign sat_c = gray_div_s[DIV_STAGES-1] ? '0 : sat_quo;
	assign ls_prod_c = {17'b0, l_c} * {17'b0, sat_c};

	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic [UNIT_W-1:0] l_s11, s_s11, ls_s11;
	logic [15:0] h_s11;
	logic lowsat_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s11 <= l_c;
			s_s11 <= sat_c;
			ls_s11 <= ls_prod_c[32:16];
			h_s11 <= hue_quo[15:0];
			lowsat_s11 <= (sat_c < SAT_GRAY);
		end
	end

	// stage 12: q and the three hue offsets
	logic [19:0] qsum_c;
	logic [UNIT_W-1:0] t_c [3];
	logic [UNIT_W-1:0] hx_c;

	always_comb begin
		hx_c = {1'b0, h_s11};
		if (l_s11 < HALF_Q16)
			qsum_c = {3'b0, l_s11} + {3'b0, ls_s11};
		else
			qsum_c = {3'b0, l_s11} + {3'b0, s_s11} - {3'b0, ls_s11};
		t_c[0] = hx_c + THIRD_Q16;
		if (t_c[0] > ONE_Q16) t_c[0] = t_c[0] - ONE_Q16;
		t_c[1] = hx_c;
		if (hx_c < THIRD_Q16)
			t_c[2] = hx_c + (ONE_Q16 - THIRD_Q16);
		else
			t_c[2] = hx_c - THIRD_Q16;
	end

	logic [UNIT_W-1:0] l_s12, q_s12;
	logic [UNIT_W-1:0] t_s12 [3];
	logic lowsat_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s12 <= l_s11;
			q_s12 <= clamp_unit($signed(qsum_c));
			for (int c = 0; c < 3; c++) t_s12[c] <= t_c[c];
			lowsat_s12 <= lowsat_s11;
		end
	end

	// stage 13: p, q-p, segment and slope factor
	logic [UNIT_W-1:0] p_c, diff_c;
	seg_t seg_c [3];
	logic [13:0] f_c [3];

	always_comb begin
		p_c = clamp_unit($signed({2'b0, l_s12, 1'b0}) - $signed({3'b0, q_s12}));
		diff_c = (q_s12 > p_c) ? q_s12 - p_c : '0;
		for (int c = 0; c < 3; c++) begin
			priority if (t_s12[c] < SIXTH_Q16) begin
				seg_c[c] = SEG_RISE;
				f_c[c] = t_s12[c][13:0];
			end else if (t_s12[c] < HALF_Q16) begin
				seg_c[c] = SEG_HIGH;
				f_c[c] = '0;
			end else if (t_s12[c] < TWO3_Q16) begin
				seg_c[c] = SEG_FALL;
				f_c[c] = 14'(TWO3_Q16 - t_s12[c]);
			end else begin
				seg_c[c] = SEG_LOW;
				f_c[c] = '0;
			end
		end
	end

	logic [UNIT_W-1:0] l_s13, p_s13, q_s13, diff_s13;
	seg_t seg_s13 [3];
	logic [13:0] f_s13 [3];
	logic lowsat_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s13 <= l_s12;
			p_s13 <= p_c;
			q_s13 <= q_s12;
			diff_s13 <= diff_c;
			for (int c = 0; c < 3; c++) begin
				seg_s13[c] <= seg_c[c];
				f_s13[c] <= f_c[c];
			end
			lowsat_s13 <= lowsat_s12;
		end
	end

	// stage 14: ramp products
	logic [33:0] prod_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			prod_c[c] = {17'b0, diff_s13} * {17'b0, 17'({3'b0, f_s13[c]} * 17'd6)};
	end

	logic [UNIT_W-1:0] l_s14, p_s14, q_s14;
	logic [17:0] prod_s14 [3];
	seg_t seg_s14 [3];
	logic lowsat_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s14 <= l_s13;
			p_s14 <= p_s13;
			q_s14 <= q_s13;
			for (int c = 0; c < 3; c++) begin
				prod_s14[c] <= prod_c[c][33:16];
				seg_s14[c] <= seg_s13[c];
			end
			lowsat_s14 <= lowsat_s13;
		end
	end

	// stage 15: channel value
	logic [18:0] vs_c [3];
	logic [UNIT_W-1:0] v_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			unique case (seg_s14[c])
				SEG_RISE, SEG_FALL: vs_c[c] = {2'b0, p_s14} + {1'b0, prod_s14[c]};
				SEG_HIGH:           vs_c[c] = {2'b0, q_s14};
				default:            vs_c[c] = {2'b0, p_s14};
			endcase
			if (lowsat_s14)
				v_c[c] = l_s14;
			else if (vs_c[c] > {2'b0, ONE_Q16})
				v_c[c] = ONE_Q16;
			else
				v_c[c] = vs_c[c][UNIT_W-1:0];
		end
	end

	logic [UNIT_W-1:0] ch_s15 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) ch_s15[c] <= v_c[c];
		end
	end

	// stage 16: bytes
	logic [24:0] byte_c [3];
	logic [COLOR_W-1:0] color_s16;

	always_comb begin
		for (int c = 0; c < 3; c++)
			byte_c[c] = {ch_s15[c], 8'b0} - {8'b0, ch_s15[c]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_s16 <= {byte_c[2][23:16], byte_c[1][23:16], byte_c[0][23:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_div_s[DIV_STAGES-1];
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	assign adv = !(v_s16 && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s16;
	assign color_out = color_s16;

endmodule

@@ design/hla_chk.sv @@
`include "assert_macros.svh"

module hla_chk import hla_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [COLOR_W-1:0]        color_in,
	input logic signed [DELTA_W-1:0] lightness_delta,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [COLOR_W-1:0]        color_out
);

	`HLA_ASSERT_ALL(a_rst_empty, !arst_n |-> !out_valid, "output valid during reset")
	`HLA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(color_out), "stalled request changed")
	`HLA_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output stall")
	`HLA_ASSERT(a_drain, !in_stall |=> $past(in_valid) || !in_stall || out_valid, "stall from empty pipe")
	`HLA_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable({color_in, lightness_delta}), "input moved")

endmodule

bind hsl_lightness_adjust hla_chk u_hla_chk (.*);
